FILE: design/clwc_pkg.sv
// Package for the circular list with cursor: operation and status codes,
// state encoding, memory command structs and payload widths.
// No dependencies.
`default_nettype none

package clwc_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int ECOUNT_W     = 5;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 48;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_LINK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Write enables of the slot store.
   typedef struct packed {
      logic value_we;
      logic next_we;
      logic prev_we;
   } store_we_type;

   // Commands to the slot allocator.
   typedef struct packed {
      logic pop;
      logic push;
      logic clear_all;
   } alloc_cmd_type;

endpackage

`default_nettype wire

FILE: design/clwc_slot_store.sv
// Slot store: value, next-link and previous-link memories, one write and one
// registered read port each. Depends on clwc_pkg.
`default_nettype none

module clwc_slot_store
   import clwc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                              clock,
   input  wire store_we_type                      we,
   input  wire logic [$clog2(CAPACITY)-1:0]       value_waddr,
   input  wire logic [VALUE_W-1:0]                value_wdata,
   input  wire logic [$clog2(CAPACITY)-1:0]       next_waddr,
   input  wire logic [$clog2(CAPACITY)-1:0]       next_wdata,
   input  wire logic [$clog2(CAPACITY)-1:0]       prev_waddr,
   input  wire logic [$clog2(CAPACITY)-1:0]       prev_wdata,
   input  wire logic [$clog2(CAPACITY)-1:0]       link_raddr,
   input  wire logic [$clog2(CAPACITY)-1:0]       value_raddr,
   output logic      [$clog2(CAPACITY)-1:0]       next_rdata,
   output logic      [$clog2(CAPACITY)-1:0]       prev_rdata,
   output logic      [VALUE_W-1:0]                value_rdata
);

   localparam int IDX_W = $clog2(CAPACITY);

   logic [VALUE_W-1:0] value_mem [CAPACITY];
   logic [IDX_W-1:0]   next_mem  [CAPACITY];
   logic [IDX_W-1:0]   prev_mem  [CAPACITY];

   logic [VALUE_W-1:0] value_rd_ff;
   logic [IDX_W-1:0]   next_rd_ff;
   logic [IDX_W-1:0]   prev_rd_ff;

   // The value port is write-first so that a value written into the slot
   // under the cursor shows up on the next cycle.
   always_ff @(posedge clock) begin
      if (we.value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      if (we.value_we && (value_waddr == value_raddr)) begin
         value_rd_ff <= value_wdata;
      end else begin
         value_rd_ff <= value_mem[value_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (we.next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (we.prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[link_raddr];
   end

   assign next_rdata  = next_rd_ff;
   assign prev_rdata  = prev_rd_ff;
   assign value_rdata = value_rd_ff;

endmodule

`default_nettype wire

FILE: design/clwc_alloc.sv
// Slot allocator: a fresh-slot watermark plus a stack of freed slots held in
// a synchronous memory. Depends on clwc_pkg.
`default_nettype none

module clwc_alloc
   import clwc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire alloc_cmd_type                 cmd,
   input  wire logic [$clog2(CAPACITY)-1:0]   push_slot,
   output logic      [$clog2(CAPACITY)-1:0]   alloc_slot
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [IDX_W-1:0] free_mem [CAPACITY];
   logic [IDX_W-1:0] free_rd_ff;
   logic [CNT_W-1:0] sp_ff, sp_in;
   logic [CNT_W-1:0] water_ff, water_in;
   logic [CNT_W-1:0] sp_dec;

   assign sp_dec = sp_ff - CNT_W'(1);

   // The top of the stack is read every cycle; the sequencer only uses it
   // after the stack pointer has settled.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         free_mem[sp_ff[IDX_W-1:0]] <= push_slot;
      end
      free_rd_ff <= free_mem[sp_dec[IDX_W-1:0]];
   end

   assign alloc_slot = (sp_ff != '0) ? free_rd_ff : water_ff[IDX_W-1:0];

   always_comb begin
      sp_in    = sp_ff;
      water_in = water_ff;
      priority if (cmd.clear_all) begin
         sp_in    = '0;
         water_in = '0;
      end else if (cmd.push) begin
         sp_in = sp_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         if (sp_ff != '0) begin
            sp_in = sp_dec;
         end else begin
            water_in = water_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         water_ff <= '0;
      end else begin
         sp_ff    <= sp_in;
         water_ff <= water_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/circular_list_with_cursor.sv
// Top level of the circular list with cursor: transfer handshakes, the
// operation sequencer and the result register. Depends on clwc_pkg,
// clwc_slot_store and clwc_alloc.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_tvalid/req_tready | req_tdata: func, item_value
//   rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: ok, status,
//           |           |                       |   cursor_value, element_count,
//           |           |                       |   is_empty
//
// Steps per operation: a clear or a refused operation goes straight to the
// done step, advance and remove go through the execute step, and an append
// does too but also takes a link step unless the list was empty, because each
// link memory has one write port and an append writes two entries in each.
// Reset is synchronous and active high; it empties the list at once, with no
// clearing pass over the memories.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; the sequencer only stalls in its final step if
// that register is still full.
`default_nettype none

module circular_list_with_cursor
   import clwc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,  // [1:0] func, [33:2] item_value
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_DATA_W-1:0]  rsp_tdata   // [0] ok, [2:1] status,
                                                   // [34:3] cursor_value,
                                                   // [39:35] element_count,
                                                   // [40] is_empty
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Sequencer state and operation context.
   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             ok_ff, ok_in;
   status_type       status_ff, status_in;

   // List registers: the head, the tail and the cursor are slot numbers.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;

   // Result register.
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Memory ports.
   store_we_type     store_we;
   logic [IDX_W-1:0] value_waddr, next_waddr, next_wdata, prev_waddr, prev_wdata;
   logic [IDX_W-1:0] next_rdata, prev_rdata;
   logic [VALUE_W-1:0] value_rdata;
   alloc_cmd_type    alloc_cmd;
   logic [IDX_W-1:0] alloc_slot;

   logic             req_fire;
   op_type           req_op;
   logic             list_empty;
   logic             out_free;
   logic [ECOUNT_W-1:0] count_field;
   logic [VALUE_W-1:0] cursor_value;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tdata[1:0]);
   assign list_empty = (count_ff == '0);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   clwc_slot_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock       (clock),
      .we          (store_we),
      .value_waddr (value_waddr),
      .value_wdata (value_ff),
      .next_waddr  (next_waddr),
      .next_wdata  (next_wdata),
      .prev_waddr  (prev_waddr),
      .prev_wdata  (prev_wdata),
      .link_raddr  (cursor_ff),
      .value_raddr (cursor_in),
      .next_rdata  (next_rdata),
      .prev_rdata  (prev_rdata),
      .value_rdata (value_rdata)
   );

   clwc_alloc #(
      .CAPACITY (CAPACITY)
   ) u_alloc (
      .clock      (clock),
      .reset      (reset),
      .cmd        (alloc_cmd),
      .push_slot  (cursor_ff),
      .alloc_slot (alloc_slot)
   );

   // The value read port always follows the next cursor, so its output is
   // the value under the current cursor.
   assign count_field  = ECOUNT_W'(count_ff);
   assign cursor_value = list_empty ? '0 : value_rdata;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      ok_in         = ok_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cursor_in     = cursor_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      store_we      = '0;
      value_waddr   = slot_ff;
      next_waddr    = slot_ff;
      next_wdata    = head_ff;
      prev_waddr    = slot_ff;
      prev_wdata    = tail_ff;
      alloc_cmd     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_op;
               value_in  = req_tdata[VALUE_W+1:2];
               ok_in     = 1'b1;
               status_in = STAT_DONE;
               state_in  = ST_EXEC;
               unique case (req_op)
                  OP_APPEND: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        ok_in     = 1'b0;
                        status_in = STAT_FULL;
                        state_in  = ST_DONE;
                     end
                  end
                  OP_REMOVE, OP_ADVANCE: begin
                     if (list_empty) begin
                        ok_in     = 1'b0;
                        status_in = STAT_EMPTY;
                        state_in  = ST_DONE;
                     end
                  end
                  OP_CLEAR: begin
                     count_in            = '0;
                     head_in             = '0;
                     tail_in             = '0;
                     cursor_in           = '0;
                     alloc_cmd.clear_all = 1'b1;
                     state_in            = ST_DONE;
                  end
               endcase
            end
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_APPEND: begin
                  // Take a slot, store the value and link the new slot from the old
                  // tail and into the head's back link, or to itself on an empty list.
                  slot_in            = alloc_slot;
                  alloc_cmd.pop      = 1'b1;
                  store_we.value_we  = 1'b1;
                  store_we.next_we   = 1'b1;
                  store_we.prev_we   = 1'b1;
                  value_waddr        = alloc_slot;
                  next_wdata         = alloc_slot;
                  prev_wdata         = alloc_slot;
                  count_in           = count_ff + CNT_W'(1);
                  if (list_empty) begin
                     next_waddr = alloc_slot;
                     prev_waddr = alloc_slot;
                     head_in    = alloc_slot;
                     tail_in    = alloc_slot;
                     cursor_in  = alloc_slot;
                  end else begin
                     next_waddr = tail_ff;
                     prev_waddr = head_ff;
                     state_in   = ST_LINK;
                  end
               end
               OP_REMOVE: begin
                  // Bridge the neighbors and give the slot back.
                  store_we.next_we = 1'b1;
                  store_we.prev_we = 1'b1;
                  next_waddr       = prev_rdata;
                  next_wdata       = next_rdata;
                  prev_waddr       = next_rdata;
                  prev_wdata       = prev_rdata;
                  alloc_cmd.push   = 1'b1;
                  count_in         = count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     alloc_cmd.clear_all = 1'b1;
                     head_in             = '0;
                     tail_in             = '0;
                     cursor_in           = '0;
                  end else begin
                     cursor_in = next_rdata;
                     if (head_ff == cursor_ff) begin
                        head_in = next_rdata;
                     end
                     if (tail_ff == cursor_ff) begin
                        tail_in = prev_rdata;
                     end
                  end
               end
               OP_ADVANCE: begin
                  cursor_in = next_rdata;
               end
               OP_CLEAR: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_LINK: begin
            // Second half of an append: the new slot's own links.
            store_we.next_we = 1'b1;
            store_we.prev_we = 1'b1;
            tail_in          = slot_ff;
            state_in         = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {
                  {(RSP_DATA_W - VALUE_W - ECOUNT_W - 4){1'b0}},
                  list_empty,
                  count_field,
                  cursor_value,
                  status_ff,
                  ok_ff
               };
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         cursor_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cursor_ff     <= cursor_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      value_ff     <= value_in;
      slot_ff      <= slot_in;
      ok_ff        <= ok_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTH
   // The element count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count exceeds capacity");

   // The execute step is entered only right after a request transfer.
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $past(req_tvalid && req_tready))
      else $error("execute step without a request transfer");

   // Remove and advance only execute on a list that holds elements.
   a_exec_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && (op_ff == OP_REMOVE || op_ff == OP_ADVANCE))
         |-> (count_ff != '0))
      else $error("remove or advance executed on an empty list");

   // A finished operation whose result register is free presents its result.
   a_done_presents: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("finished operation did not present a result");
`endif

endmodule

`default_nettype wire
